FILE: hw/rtl/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// Shared widths, codes and arithmetic helpers of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

  // Default sizes
  localparam int unsigned StoreDepth = 65536;
  localparam int unsigned MaxSide    = 256;

  // Field widths
  localparam int unsigned IndexW  = 16;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned WgtW    = 8;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned TexelW  = ChanW * NumChan;
  localparam int unsigned ColorW  = 16;
  localparam int unsigned CfgW    = 9;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned NumTaps = 4;

  // Request codes
  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_type_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [ChanW-1:0]  chan_t;
  typedef logic [ColorW-1:0] color_t;
  typedef logic [WgtW-1:0]   wgt_t;

  // Horizontal lerp: a*(256-w) + b*w, exact, at most 255*256
  function automatic color_t lerp_h(input chan_t a, input chan_t b, input wgt_t w);
    logic [WgtW:0]   wn;
    logic [ColorW:0] acc;
    wn  = (WgtW+1)'(1 << WgtW) - {1'b0, w};
    acc = (ColorW+1)'(a) * (ColorW+1)'(wn) + (ColorW+1)'(b) * (ColorW+1)'(w);
    return acc[ColorW-1:0];
  endfunction

  // Vertical lerp: (t*(256-w) + b*w) >> 8, truncated
  function automatic color_t lerp_v(input color_t t, input color_t b, input wgt_t w);
    logic [WgtW:0]             wn;
    logic [ColorW+WgtW:0]      acc;
    wn  = (WgtW+1)'(1 << WgtW) - {1'b0, w};
    acc = (ColorW+WgtW+1)'(t) * (ColorW+WgtW+1)'(wn)
        + (ColorW+WgtW+1)'(b) * (ColorW+WgtW+1)'(w);
    return acc[WgtW +: ColorW];
  endfunction

endpackage

FILE: hw/rtl/bilinear_texture_sampler.sv
// Bilinear texture sampler. Takes one beat per cycle while stall_o is low,
// write or sample, and presents the filtered color of a sample in the output
// register; write beats return nothing. The rate of one beat per cycle is
// set by the texture store, held as four identical copies that each take every
// write and serve one of the four neighbor taps, so each copy sees one write
// port and one read port per cycle. Every sample sees all writes accepted
// before it. Stages: scale (u,v times size), tap/row compute, store read,
// horizontal lerp, vertical lerp into the output register. Each stage holds
// its beat while the next is full and stalled, so bubbles close up and input
// is still taken while a result waits at the output if a stage is empty. The
// store is not cleared after reset; STORE_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
// bilinear_texture_sampler
// RGB texture store with a pipelined repeat-wrap bilinear filter.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler #(
  parameter int unsigned STORE_DEPTH = bts_pkg::StoreDepth,
  parameter int unsigned MAX_SIDE    = bts_pkg::MaxSide
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bts_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bts_pkg::CfgW-1:0]     cfg_data_i,
  // request channel
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic                         req_type_i,
  input  logic [bts_pkg::IndexW-1:0]   texel_index_i,
  input  logic [bts_pkg::ChanW-1:0]    texel_red_i,
  input  logic [bts_pkg::ChanW-1:0]    texel_green_i,
  input  logic [bts_pkg::ChanW-1:0]    texel_blue_i,
  input  logic signed [bts_pkg::CoordW-1:0] tex_u_i,
  input  logic signed [bts_pkg::CoordW-1:0] tex_v_i,
  // result channel
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [bts_pkg::ColorW-1:0]   color_red_o,
  output logic [bts_pkg::ColorW-1:0]   color_green_o,
  output logic [bts_pkg::ColorW-1:0]   color_blue_o
);
  import bts_pkg::*;

  localparam int unsigned AddrW = $clog2(STORE_DEPTH);
  localparam int unsigned SideW = $clog2(MAX_SIDE + 1);
  localparam int unsigned ScW   = FracW + SideW;
  localparam int unsigned RowW  = 2 * SideW;
  localparam int unsigned SumW  = RowW + 1;

  // --------------------------------------------------------------------------
  // Configuration: sizes are stored already clamped to 1..MAX_SIDE
  // --------------------------------------------------------------------------
  logic [SideW-1:0] width_q, height_q, cfg_size;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_size = SideW'(1);
    end else if (32'(cfg_data_i) > MAX_SIDE) begin
      cfg_size = SideW'(MAX_SIDE);
    end else begin
      cfg_size = SideW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SideW'(1);
      height_q <= SideW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_TEX_WIDTH:  width_q  <= cfg_size;
        REG_TEX_HEIGHT: height_q <= cfg_size;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its beat moves on
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic s2_type_q;

  always_comb begin
    rdy5 = !s5_valid_q || !stall_i;
    rdy4 = !s4_valid_q || rdy5;
    rdy3 = !s3_valid_q || rdy4;
    rdy2 = !s2_valid_q || rdy3;
    rdy1 = !s1_valid_q || rdy2;
  end

  assign stall_o = !rdy1;
  assign valid_o = s5_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (rdy1) s1_valid_q <= valid_i;
      if (rdy2) s2_valid_q <= s1_valid_q;
      // write beats end at the store
      if (rdy3) s3_valid_q <= s2_valid_q && (s2_type_q == REQ_SAMPLE);
      if (rdy4) s4_valid_q <= s3_valid_q;
      if (rdy5) s5_valid_q <= s4_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: fraction times size (repeat wrap keeps the low 16 bits)
  // --------------------------------------------------------------------------
  logic                 s1_type_q;
  logic [IndexW-1:0]    s1_idx_q;
  logic [TexelW-1:0]    s1_texel_q;
  logic [ScW-1:0]       s1_su_q, s1_sv_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_type_q  <= req_type_i;
      s1_idx_q   <= texel_index_i;
      s1_texel_q <= {texel_red_i, texel_green_i, texel_blue_i};
      s1_su_q    <= ScW'(tex_u_i[FracW-1:0]) * ScW'(width_q);
      s1_sv_q    <= ScW'(tex_v_i[FracW-1:0]) * ScW'(height_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: taps, weights, clamped neighbors and row offsets
  // --------------------------------------------------------------------------
  logic [SideW-1:0] x0, y0, x1, y1;
  logic [SideW:0]   x0p1, y0p1;

  always_comb begin
    x0   = s1_su_q[FracW +: SideW];
    y0   = s1_sv_q[FracW +: SideW];
    x0p1 = {1'b0, x0} + (SideW+1)'(1);
    y0p1 = {1'b0, y0} + (SideW+1)'(1);
    x1   = (x0p1 < {1'b0, width_q})  ? x0p1[SideW-1:0] : width_q - SideW'(1);
    y1   = (y0p1 < {1'b0, height_q}) ? y0p1[SideW-1:0] : height_q - SideW'(1);
  end

  logic [IndexW-1:0]    s2_idx_q;
  logic [TexelW-1:0]    s2_texel_q;
  logic [SideW-1:0]     s2_x0_q, s2_x1_q;
  logic [RowW-1:0]      s2_row0_q, s2_row1_q;
  wgt_t                 s2_wx_q, s2_wy_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_type_q  <= s1_type_q;
      s2_idx_q   <= s1_idx_q;
      s2_texel_q <= s1_texel_q;
      s2_x0_q    <= x0;
      s2_x1_q    <= x1;
      s2_row0_q  <= RowW'(y0) * RowW'(width_q);
      s2_row1_q  <= RowW'(y1) * RowW'(width_q);
      s2_wx_q    <= s1_su_q[FracW-1 -: WgtW];
      s2_wy_q    <= s1_sv_q[FracW-1 -: WgtW];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: texture store, four copies, one tap each
  // --------------------------------------------------------------------------
  logic [AddrW-1:0]  rd_addr [NumTaps];
  logic [AddrW-1:0]  wr_addr;
  logic              wr_en;
  logic [TexelW-1:0] tap_q [NumTaps];

  always_comb begin
    // taps: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1)
    rd_addr[0] = AddrW'(SumW'(s2_row0_q) + SumW'(s2_x0_q));
    rd_addr[1] = AddrW'(SumW'(s2_row0_q) + SumW'(s2_x1_q));
    rd_addr[2] = AddrW'(SumW'(s2_row1_q) + SumW'(s2_x0_q));
    rd_addr[3] = AddrW'(SumW'(s2_row1_q) + SumW'(s2_x1_q));
    wr_addr    = AddrW'(s2_idx_q);
    wr_en      = rdy3 && s2_valid_q && (s2_type_q == REQ_WRITE)
              && (32'(s2_idx_q) < STORE_DEPTH);
  end

  for (genvar b = 0; b < NumTaps; b++) begin : g_bank
    logic [TexelW-1:0] mem_q [STORE_DEPTH];

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        mem_q[wr_addr] <= s2_texel_q;
      end
      if (rdy3) begin
        tap_q[b] <= mem_q[rd_addr[b]];
      end
    end
  end

  wgt_t s3_wx_q, s3_wy_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_wx_q <= s2_wx_q;
      s3_wy_q <= s2_wy_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: horizontal lerps, per channel (red first)
  // --------------------------------------------------------------------------
  color_t top_d [NumChan];
  color_t bot_d [NumChan];
  color_t s4_top_q [NumChan];
  color_t s4_bot_q [NumChan];
  wgt_t   s4_wy_q;

  always_comb begin
    for (int k = 0; k < NumChan; k++) begin
      top_d[k] = lerp_h(tap_q[0][TexelW-1-ChanW*k -: ChanW],
                        tap_q[1][TexelW-1-ChanW*k -: ChanW], s3_wx_q);
      bot_d[k] = lerp_h(tap_q[2][TexelW-1-ChanW*k -: ChanW],
                        tap_q[3][TexelW-1-ChanW*k -: ChanW], s3_wx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      s4_top_q <= top_d;
      s4_bot_q <= bot_d;
      s4_wy_q  <= s3_wy_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: vertical lerp into the output register
  // --------------------------------------------------------------------------
  color_t s5_color_q [NumChan];

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      for (int k = 0; k < NumChan; k++) begin
        s5_color_q[k] <= lerp_v(s4_top_q[k], s4_bot_q[k], s4_wy_q);
      end
    end
  end

  assign color_red_o   = s5_color_q[0];
  assign color_green_o = s5_color_q[1];
  assign color_blue_o  = s5_color_q[2];

endmodule
